>>> rtl/setex_pkg.sv
// ----------------------------------------------------------------------------
// setex_pkg
// Shared types and constants of the sprite entry tile expander.
// ----------------------------------------------------------------------------
package setex_pkg;

  localparam logic [9:0] FLIP_ORIGIN = 10'd240;
  localparam logic [9:0] WRAP_SHIFT  = 10'd256;
  localparam int         TILE_SHIFT  = 4;

  localparam logic [1:0] CNT_ZERO  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  localparam int DESC_W = 8 + 4 + 9 + 10 + 2 + 1;

  typedef struct packed {
    logic [7:0]        code;
    logic [3:0]        color;
    logic signed [8:0] x0;
    logic signed [9:0] y0;
    logic [1:0]        extra;
    logic              mirror;
  } desc_t;

  typedef struct packed {
    logic signed [9:0] draw_y;
    logic signed [8:0] draw_x;
    logic [3:0]        color;
    logic [8:0]        tile_code;
  } cmd_t;

endpackage

>>> rtl/setex_front.sv
// ----------------------------------------------------------------------------
// setex_front
// Accept sprite entries, decode count and apply screen flip into a descriptor.
// ----------------------------------------------------------------------------
module setex_front
  import setex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        flip,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  output logic        q_push,
  input  logic        q_ready,
  output desc_t       q_data
);

  logic  desc_valid_r, desc_valid_nxt;
  desc_t desc_r, desc_nxt;
  logic  accept;
  logic [7:0] base_code, attributes, pos_y, pos_x;

  assign base_code  = in_tdata[7:0];
  assign attributes = in_tdata[15:8];
  assign pos_y      = in_tdata[23:16];
  assign pos_x      = in_tdata[31:24];

  assign q_push    = desc_valid_r && q_ready;
  assign in_tready = !desc_valid_r || q_ready;
  assign accept    = in_tvalid && in_tready;
  assign q_data    = desc_r;

  always_comb begin
    desc_nxt        = desc_r;
    desc_valid_nxt  = desc_valid_r;
    if (q_push) begin
      desc_valid_nxt = 1'b0;
    end
    if (accept) begin
      desc_valid_nxt  = 1'b1;
      desc_nxt.code   = base_code;
      desc_nxt.color  = attributes[3:0];
      desc_nxt.mirror = flip;
      case (attributes[7:6])
        CNT_TWO: desc_nxt.extra = CNT_THREE;
        default: desc_nxt.extra = attributes[7:6];
      endcase
      if (flip) begin
        desc_nxt.x0 = 9'(FLIP_ORIGIN - {2'b00, pos_x});
        desc_nxt.y0 = FLIP_ORIGIN - {2'b00, pos_y};
      end else begin
        desc_nxt.x0 = {1'b0, pos_x};
        desc_nxt.y0 = {2'b00, pos_y};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
    end
    desc_r <= desc_nxt;
  end

endmodule

>>> rtl/setex_queue.sv
// ----------------------------------------------------------------------------
// setex_queue
// Short descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module setex_queue
  import setex_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  ready,
  input  desc_t wr_data,
  output logic  valid,
  input  logic  pop,
  output desc_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t           mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign ready   = cnt_r != CW'(DEPTH);
  assign valid   = cnt_r != '0;
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/setex_back.sv
// ----------------------------------------------------------------------------
// setex_back
// Walk one descriptor from the highest tile down, one draw command per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module setex_back
  import setex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  desc_t       q_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic       busy_r, busy_nxt;
  desc_t      desc_r, desc_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       copy_r, copy_nxt;
  logic       out_valid_r, out_valid_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic       mirror_r, mirror_nxt;
  logic       last_r, last_nxt;
  logic       emit, fin, load;
  logic [9:0] step, y_prim, y_copy;

  assign emit  = busy_r && (!out_valid_r || out_tready);
  assign fin   = copy_r && (idx_r == CNT_ZERO);
  assign load  = q_valid && (!busy_r || (emit && fin));
  assign q_pop = load;

  assign step   = {4'b0000, idx_r, 4'b0000};
  assign y_prim = desc_r.mirror ? desc_r.y0 - step : desc_r.y0 + step;
  assign y_copy = desc_r.mirror ? y_prim + WRAP_SHIFT : y_prim - WRAP_SHIFT;

  always_comb begin
    busy_nxt      = busy_r;
    desc_nxt      = desc_r;
    idx_nxt       = idx_r;
    copy_nxt      = copy_r;
    cmd_nxt       = cmd_r;
    mirror_nxt    = mirror_r;
    last_nxt      = last_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (emit) begin
      out_valid_nxt     = 1'b1;
      cmd_nxt.tile_code = {1'b0, desc_r.code} + {7'd0, idx_r};
      cmd_nxt.color     = desc_r.color;
      cmd_nxt.draw_x    = desc_r.x0;
      cmd_nxt.draw_y    = copy_r ? y_copy : y_prim;
      mirror_nxt        = desc_r.mirror;
      last_nxt          = fin;
      if (fin) begin
        busy_nxt = 1'b0;
      end else if (copy_r) begin
        idx_nxt  = idx_r - 1'b1;
        copy_nxt = 1'b0;
      end else begin
        copy_nxt = 1'b1;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      desc_nxt = q_data;
      idx_nxt  = q_data.extra;
      copy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    desc_r   <= desc_nxt;
    idx_r    <= idx_nxt;
    copy_r   <= copy_nxt;
    cmd_r    <= cmd_nxt;
    mirror_r <= mirror_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cmd_r;
  assign out_tuser  = mirror_r;
  assign out_tlast  = last_r;

endmodule

>>> rtl/sprite_entry_tile_expander.sv
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander
// Expand four-byte sprite entries into tile draw commands with wrap copies.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | one sprite entry per transfer
//  out_    | master    | one draw command per transfer, tlast on the entry's end
//  cfg_    | slave     | screen flip bit
//
//  An entry gives 2, 4 or 8 commands; the back-end sequencer emits one per
//  cycle while out_tready does not stall it, and takes the next entry with the last.
//  An entry is registered in the front, queue, back-end and command registers in turn.
//  Reset is synchronous, active low; flip resets to 0.
//  Front and back stall independently through a queue of QUEUE_DEPTH entries.
// ----------------------------------------------------------------------------
module sprite_entry_tile_expander
  import setex_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,    // flip
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // base_code, attributes, pos_y, pos_x
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // tile_code, color, draw_x, draw_y
  output logic        out_tuser,   // mirror
  output logic        out_tlast
);

  logic  flip_r, flip_nxt;
  logic  q_push, q_ready, q_valid, q_pop;
  desc_t q_wr_data, q_rd_data;

  assign cfg_ready = 1'b1;
  assign flip_nxt  = (cfg_valid && cfg_ready) ? cfg_data : flip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r <= 1'b0;
    end else begin
      flip_r <= flip_nxt;
    end
  end

  setex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .flip      (flip_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_data    (q_wr_data)
  );

  setex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .ready   (q_ready),
    .wr_data (q_wr_data),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_data (q_rd_data)
  );

  setex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_mirror_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == flip_r)
    else $error("mirror flag differs from flip register");

  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside one entry's commands");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("push into full queue");

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> bench/setex_draw_checker.sv
// ----------------------------------------------------------------------------
// setex_draw_checker
// Watches the flip, entry and draw command channels of the sprite entry tile
// expander. Every accepted entry is expanded into the expected draw commands.
// Each command on the output is compared field by field with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module setex_draw_checker
  import setex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // base_code, attributes, pos_y, pos_x
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // tile_code, color, draw_x, draw_y
  input  logic        out_tuser,   // mirror
  input  logic        out_tlast,
  input  logic        drain_done,
  output int          pending,
  output int          mismatches,
  output int          cmds_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_t cmd;
    logic mirror;
    logic last;
  } draw_cmd_t;

  logic      flip_q;
  draw_cmd_t draw_q[$];
  draw_cmd_t want;
  draw_cmd_t got;
  bit        leftover_reported;

  function automatic void expand_entry(input logic [31:0] entry, input logic flip);
    logic [7:0] base;
    logic [7:0] attr;
    int         x0;
    int         y0;
    int         dir;
    int         extra;
    int         yp;
    draw_cmd_t  c;
    base  = entry[7:0];
    attr  = entry[15:8];
    y0    = int'(entry[23:16]);
    x0    = int'(entry[31:24]);
    dir   = 1;
    if (flip) begin
      x0  = int'(FLIP_ORIGIN) - x0;
      y0  = int'(FLIP_ORIGIN) - y0;
      dir = -1;
    end
    extra = int'(attr[7:6]);
    if (attr[7:6] == CNT_TWO) begin
      extra = int'(CNT_THREE);
    end
    for (int i = extra; i >= 0; i--) begin
      yp              = y0 + (i << TILE_SHIFT) * dir;
      c.cmd.tile_code = 9'(int'(base) + i);
      c.cmd.color     = attr[3:0];
      c.cmd.draw_x    = 9'(x0);
      c.cmd.draw_y    = 10'(yp);
      c.mirror        = flip;
      c.last          = 1'b0;
      draw_q.push_back(c);
      c.cmd.draw_y    = 10'(yp - int'(WRAP_SHIFT) * dir);
      c.last          = (i == 0);
      draw_q.push_back(c);
    end
  endfunction

  function automatic void check_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      flip_q            <= 1'b0;
      pending           <= 0;
      mismatches        = 0;
      cmds_checked      = 0;
      leftover_reported = 1'b0;
      draw_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        flip_q <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        expand_entry(in_tdata, flip_q);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser, out_tlast};
        if (draw_q.size() == 0) begin
          $display("%0t: unexpected draw command, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = draw_q.pop_front();
          check_field("tile_code", int'(want.cmd.tile_code), int'(got.cmd.tile_code));
          check_field("color", int'(want.cmd.color), int'(got.cmd.color));
          check_field("draw_x", int'(want.cmd.draw_x), int'(got.cmd.draw_x));
          check_field("draw_y", int'(want.cmd.draw_y), int'(got.cmd.draw_y));
          check_field("mirror", int'(want.mirror), int'(got.mirror));
          check_field("last", int'(want.last), int'(got.last));
          cmds_checked++;
        end
      end
      pending <= draw_q.size();
      if (drain_done && !leftover_reported) begin
        leftover_reported = 1'b1;
        if (draw_q.size() != 0) begin
          $display("%0t: draw commands missing, expected 0 left, got %0d", $time,
                   draw_q.size());
          mismatches += draw_q.size();
        end
      end
    end
  end

endmodule

>>> bench/tb_sprite_entry_tile_expander.sv
// ----------------------------------------------------------------------------
// tb_sprite_entry_tile_expander
// Drives sprite entries and flip settings into the tile expander with bursty
// input and a stalling output. A directed set covers every tile count and the
// field extremes under both flip settings, then random entries follow over
// alternating flip phases. The checker judges every draw command.
// ----------------------------------------------------------------------------
module tb_sprite_entry_tile_expander;
  import setex_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 212;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_TOGGLE
  } ready_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_data   = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        drain_done = 1'b0;

  int          draws_pending;
  int          draw_errors;
  int          draws_checked;
  int          entries_sent;
  int          burst_left;
  int          cycle_count;
  int          ready_run;
  ready_mode_e ready_mode;

  logic [31:0] directed_entries[10] = '{
    32'h0000_0000, 32'hFFFF_0FFF, 32'h2010_4A01, 32'hF0F0_8FFE, 32'hFF00_FFFF,
    32'h00FF_C580, 32'h8080_3000, 32'h0000_B37F, 32'hEF01_7510, 32'h10F1_CFFF
  };

  sprite_entry_tile_expander i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  setex_draw_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .drain_done   (drain_done),
    .pending      (draws_pending),
    .mismatches   (draw_errors),
    .cmds_checked (draws_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sprite_entry_tile_expander");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_run  = $urandom_range(16, 80);
    end else begin
      ready_run--;
    end
    case (ready_mode)
      RDY_ALWAYS: begin
        out_tready <= 1'b1;
      end
      RDY_MOSTLY: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      RDY_RARELY: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready <= ~out_tready;
      end
    endcase
  end

  task automatic write_flip(input logic flip);
    cfg_valid <= 1'b1;
    cfg_data  <= flip;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_entry(input logic [31:0] entry);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= entry;
    do @(posedge clk); while (!in_tready);
    entries_sent++;
  endtask

  task automatic drain_entries();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (draws_pending != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int f = 0; f < 2; f++) begin
      write_flip(f[0]);
      foreach (directed_entries[k]) begin
        send_entry(directed_entries[k]);
      end
      drain_entries();
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_flip(~phase[0]);
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        send_entry($urandom());
      end
      drain_entries();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d sprite entries over both flip settings and all tile counts.",
             entries_sent);
    $display("Compared %0d draw commands against the expected expansion.", draws_checked);
    if (draw_errors == 0) begin
      $display("PASS sprite_entry_tile_expander");
    end else begin
      $display("FAIL sprite_entry_tile_expander");
    end
    $finish;
  end

endmodule
